// ===== rtl/vdpf_pkg.sv =====
// Shared constants, codes and helper functions of the voxel point filter.
package vdpf_pkg;

    localparam int MAX_POINTS  = 4096;
    localparam int TABLE_SLOTS = 8192;
    localparam int COORD_BITS  = 18;

    localparam int SLOT_BITS   = $clog2(TABLE_SLOTS);
    localparam int KEY_BITS    = 3 * COORD_BITS;
    localparam int INV_BITS    = 17;
    localparam int RNG_BITS    = 17;
    localparam int BND_BITS    = 18;
    localparam int CNT_BITS    = 32;
    localparam int KEPT_BITS   = 13;
    localparam int CFG_BITS    = 36;
    localparam int IDX_BITS    = 3;
    localparam int SQ_BITS     = 2 * COORD_BITS;
    localparam int PROD_BITS   = COORD_BITS + INV_BITS + 1;
    localparam int FRAC_BITS   = 16;

    localparam logic [KEPT_BITS-1:0] POINT_CAP = KEPT_BITS'(MAX_POINTS);

    // register indexes
    localparam logic [IDX_BITS-1:0] REG_RANGE  = 3'd0;
    localparam logic [IDX_BITS-1:0] REG_HEIGHT = 3'd1;
    localparam logic [IDX_BITS-1:0] REG_INV    = 3'd2;
    localparam logic [IDX_BITS-1:0] REG_SELF_X = 3'd3;
    localparam logic [IDX_BITS-1:0] REG_SELF_Y = 3'd4;
    localparam logic [IDX_BITS-1:0] REG_SELF_Z = 3'd5;
    localparam logic [IDX_BITS-1:0] REG_SELF_EN = 3'd6;
    localparam logic [IDX_BITS-1:0] REG_MAX_OUT = 3'd7;

    typedef enum logic [2:0] {
        VERD_ACCEPT  = 3'd0,
        VERD_INVALID = 3'd1,
        VERD_RANGE   = 3'd2,
        VERD_HEIGHT  = 3'd3,
        VERD_SELF    = 3'd4,
        VERD_DUP     = 3'd5,
        VERD_LIMIT   = 3'd6,
        VERD_CLEARED = 3'd7
    } verdict_t;

    // inclusive signed bounds: low half minimum, high half maximum
    function automatic logic in_box(input logic signed [COORD_BITS-1:0] v,
                                    input logic [2*BND_BITS-1:0] bounds);
        logic signed [BND_BITS-1:0] lo;
        logic signed [BND_BITS-1:0] hi;
        lo = $signed(bounds[BND_BITS-1:0]);
        hi = $signed(bounds[2*BND_BITS-1:BND_BITS]);
        return (v >= lo) && (v <= hi);
    endfunction

    // fold the key down to a slot index; only membership is visible
    function automatic logic [SLOT_BITS-1:0] slot_hash(input logic [KEY_BITS-1:0] key);
        logic [SLOT_BITS-1:0] h;
        h = '0;
        for (int i = 0; i < KEY_BITS; i++) begin
            h[i % SLOT_BITS] = h[i % SLOT_BITS] ^ key[i];
        end
        return h;
    endfunction

    function automatic logic [CNT_BITS-1:0] sat_inc(input logic [CNT_BITS-1:0] c);
        return (c == '1) ? c : c + CNT_BITS'(1);
    endfunction

endpackage

// ===== rtl/voxel_dedup_point_filter_core.sv =====
// Voxel-grid point filter that keeps the first point of each voxel.
// Each word is accepted in ST_IDLE; then an invalid point goes to ST_DONE, a point dropped by range,
// height or self box passes ST_MUL and ST_CHECK, a voxel lookup ST_MUL, ST_CHECK and ST_PROBE, the
// last repeated for every probed slot holding another voxel (voxel table with a registered read and
// a separate write port). ST_DONE loads the result register, holding while the last result is not taken.
// A clear command, and reset itself, sweep all TABLE_SLOTS (8192) table entries one per cycle
// before the next point is taken; configuration writes act at once, so make them only while
// no word is in flight.
module voxel_dedup_point_filter_core (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [55:0]              s_tdata,   // x_mm, y_mm, z_mm, zero pad
    input  logic [1:0]               s_tuser,   // command, point_valid
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [263:0]             m_tdata,   // out_x_mm, out_y_mm, out_z_mm, seen_count,
                                                // valid_count, range_drop_count,
                                                // height_drop_count, self_drop_count,
                                                // voxel_drop_count, kept_count, limit_hit, pad
    output logic [2:0]               m_tuser,   // verdict
    input  logic                     cfg_wr_en,
    input  logic [vdpf_pkg::IDX_BITS-1:0] cfg_index,
    input  logic [vdpf_pkg::CFG_BITS-1:0] cfg_wdata
);

    localparam int CB = vdpf_pkg::COORD_BITS;
    localparam int KB = vdpf_pkg::KEY_BITS;
    localparam int SB = vdpf_pkg::SLOT_BITS;
    localparam int NB = vdpf_pkg::CNT_BITS;
    localparam int TB = vdpf_pkg::KEPT_BITS;
    localparam int QB = vdpf_pkg::SQ_BITS;
    localparam int PB = vdpf_pkg::PROD_BITS;
    localparam int RB = vdpf_pkg::RNG_BITS;
    localparam int OUT_W = 3 * CB + 6 * NB + TB + 1;

    typedef enum logic [2:0] {
        ST_CLEAR, ST_IDLE, ST_MUL, ST_CHECK, ST_PROBE, ST_DONE
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [2*RB-1:0]  range_reg, range_next;
    logic [35:0]      height_reg, height_next;
    logic [vdpf_pkg::INV_BITS-1:0] inv_reg, inv_next;
    logic [35:0]      selfx_reg, selfx_next, selfy_reg, selfy_next, selfz_reg, selfz_next;
    logic             self_en_reg, self_en_next;
    logic [TB-1:0]    max_out_reg, max_out_next;

    // statistics
    logic [NB-1:0] seen_reg, seen_next, valid_reg, valid_next;
    logic [NB-1:0] rdrop_reg, rdrop_next, hdrop_reg, hdrop_next;
    logic [NB-1:0] sdrop_reg, sdrop_next, vdrop_reg, vdrop_next;
    logic [TB-1:0] kept_reg, kept_next;
    logic          limit_reg, limit_next;

    // point in work
    logic signed [CB-1:0] px_reg, px_next, py_reg, py_next, pz_reg, pz_next;
    logic [QB-1:0]        xx_reg, xx_next, yy_reg, yy_next;
    logic [2*RB-1:0]      rmin2_reg, rmin2_next, rmax2_reg, rmax2_next;
    logic [KB-1:0]        key_reg, key_next;
    logic [SB-1:0]        addr_reg, addr_next;
    logic                 emit_reg, emit_next;
    vdpf_pkg::verdict_t   verd_reg, verd_next;

    // result register
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0]     out_reg, out_next;
    vdpf_pkg::verdict_t   out_verd_reg, out_verd_next;

    // voxel table: used bit above the key
    logic [KB:0]   slot_mem [vdpf_pkg::TABLE_SLOTS];
    logic [KB:0]   slot_rdata_reg;
    logic          mem_we;
    logic [SB-1:0] mem_waddr;
    logic [KB:0]   mem_wdata;

    logic signed [QB-1:0] sq_x, sq_y;
    logic signed [PB-1:0] prod_x, prod_y, prod_z;
    logic signed [vdpf_pkg::INV_BITS:0] inv_s;
    logic [QB-1:0]        r2;
    logic [TB-1:0]        cap;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {(264 - OUT_W)'(0), out_reg};
    assign m_tuser  = out_verd_reg;

    assign inv_s  = $signed({1'b0, inv_reg});
    assign sq_x   = px_reg * px_reg;
    assign sq_y   = py_reg * py_reg;
    assign prod_x = px_reg * inv_s;
    assign prod_y = py_reg * inv_s;
    assign prod_z = pz_reg * inv_s;
    assign r2     = xx_reg + yy_reg;
    assign cap    = (max_out_reg > vdpf_pkg::POINT_CAP) ? vdpf_pkg::POINT_CAP : max_out_reg;

    always_comb begin
        state_next    = state_reg;
        range_next    = range_reg;
        height_next   = height_reg;
        inv_next      = inv_reg;
        selfx_next    = selfx_reg;
        selfy_next    = selfy_reg;
        selfz_next    = selfz_reg;
        self_en_next  = self_en_reg;
        max_out_next  = max_out_reg;
        seen_next     = seen_reg;
        valid_next    = valid_reg;
        rdrop_next    = rdrop_reg;
        hdrop_next    = hdrop_reg;
        sdrop_next    = sdrop_reg;
        vdrop_next    = vdrop_reg;
        kept_next     = kept_reg;
        limit_next    = limit_reg;
        px_next       = px_reg;
        py_next       = py_reg;
        pz_next       = pz_reg;
        xx_next       = xx_reg;
        yy_next       = yy_reg;
        rmin2_next    = rmin2_reg;
        rmax2_next    = rmax2_reg;
        key_next      = key_reg;
        addr_next     = addr_reg;
        emit_next     = emit_reg;
        verd_next     = verd_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        out_next      = out_reg;
        out_verd_next = out_verd_reg;
        mem_we        = 1'b0;
        mem_waddr     = addr_reg;
        mem_wdata     = '0;

        if (cfg_wr_en) begin
            case (cfg_index)
                vdpf_pkg::REG_RANGE:   range_next   = cfg_wdata[2*RB-1:0];
                vdpf_pkg::REG_HEIGHT:  height_next  = cfg_wdata;
                vdpf_pkg::REG_INV:     inv_next     = cfg_wdata[vdpf_pkg::INV_BITS-1:0];
                vdpf_pkg::REG_SELF_X:  selfx_next   = cfg_wdata;
                vdpf_pkg::REG_SELF_Y:  selfy_next   = cfg_wdata;
                vdpf_pkg::REG_SELF_Z:  selfz_next   = cfg_wdata;
                vdpf_pkg::REG_SELF_EN: self_en_next = cfg_wdata[0];
                vdpf_pkg::REG_MAX_OUT: max_out_next = cfg_wdata[TB-1:0];
                default: ;
            endcase
        end

        case (state_reg)
            ST_CLEAR: begin
                mem_we = 1'b1;
                if (addr_reg == SB'(vdpf_pkg::TABLE_SLOTS - 1)) begin
                    verd_next  = vdpf_pkg::VERD_CLEARED;
                    state_next = emit_reg ? ST_DONE : ST_IDLE;
                end else begin
                    addr_next = addr_reg + SB'(1);
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    px_next = $signed(s_tdata[CB-1:0]);
                    py_next = $signed(s_tdata[2*CB-1:CB]);
                    pz_next = $signed(s_tdata[3*CB-1:2*CB]);
                    if (s_tuser[0]) begin
                        px_next    = '0;
                        py_next    = '0;
                        pz_next    = '0;
                        seen_next  = '0;
                        valid_next = '0;
                        rdrop_next = '0;
                        hdrop_next = '0;
                        sdrop_next = '0;
                        vdrop_next = '0;
                        kept_next  = '0;
                        limit_next = 1'b0;
                        addr_next  = '0;
                        emit_next  = 1'b1;
                        state_next = ST_CLEAR;
                    end else begin
                        seen_next = vdpf_pkg::sat_inc(seen_reg);
                        if (!s_tuser[1]) begin
                            verd_next  = vdpf_pkg::VERD_INVALID;
                            state_next = ST_DONE;
                        end else begin
                            valid_next = vdpf_pkg::sat_inc(valid_reg);
                            state_next = ST_MUL;
                        end
                    end
                end
            end
            ST_MUL: begin
                xx_next    = $unsigned(sq_x);
                yy_next    = $unsigned(sq_y);
                rmin2_next = range_reg[RB-1:0] * range_reg[RB-1:0];
                rmax2_next = range_reg[2*RB-1:RB] * range_reg[2*RB-1:RB];
                // floor by arithmetic shift, wrapped to the coordinate width
                key_next   = {prod_z[vdpf_pkg::FRAC_BITS +: CB],
                              prod_y[vdpf_pkg::FRAC_BITS +: CB],
                              prod_x[vdpf_pkg::FRAC_BITS +: CB]};
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                if (r2 < QB'(rmin2_reg) || r2 > QB'(rmax2_reg)) begin
                    rdrop_next = vdpf_pkg::sat_inc(rdrop_reg);
                    verd_next  = vdpf_pkg::VERD_RANGE;
                    state_next = ST_DONE;
                end else if (!vdpf_pkg::in_box(pz_reg, height_reg)) begin
                    hdrop_next = vdpf_pkg::sat_inc(hdrop_reg);
                    verd_next  = vdpf_pkg::VERD_HEIGHT;
                    state_next = ST_DONE;
                end else if (self_en_reg && vdpf_pkg::in_box(px_reg, selfx_reg) &&
                             vdpf_pkg::in_box(py_reg, selfy_reg) &&
                             vdpf_pkg::in_box(pz_reg, selfz_reg)) begin
                    sdrop_next = vdpf_pkg::sat_inc(sdrop_reg);
                    verd_next  = vdpf_pkg::VERD_SELF;
                    state_next = ST_DONE;
                end else begin
                    addr_next  = vdpf_pkg::slot_hash(key_reg);
                    state_next = ST_PROBE;
                end
            end
            ST_PROBE: begin
                if (!slot_rdata_reg[KB]) begin
                    if (kept_reg >= cap) begin
                        limit_next = 1'b1;
                        verd_next  = vdpf_pkg::VERD_LIMIT;
                    end else begin
                        mem_we    = 1'b1;
                        mem_wdata = {1'b1, key_reg};
                        kept_next = kept_reg + TB'(1);
                        verd_next = vdpf_pkg::VERD_ACCEPT;
                    end
                    state_next = ST_DONE;
                end else if (slot_rdata_reg[KB-1:0] == key_reg) begin
                    vdrop_next = vdpf_pkg::sat_inc(vdrop_reg);
                    verd_next  = vdpf_pkg::VERD_DUP;
                    state_next = ST_DONE;
                end else begin
                    // advance to the next slot, wrapping at the table end
                    addr_next = addr_reg + SB'(1);
                end
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    out_verd_next = verd_reg;
                    out_next = {limit_reg, kept_reg, vdrop_reg, sdrop_reg, hdrop_reg,
                                rdrop_reg, valid_reg, seen_reg, pz_reg, py_reg, px_reg};
                    emit_next  = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // table reads follow the next probe address so data lands as the probe starts
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            slot_mem[mem_waddr] <= mem_wdata;
        end
        slot_rdata_reg <= slot_mem[addr_next];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            addr_reg     <= '0;
            emit_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
            range_reg    <= 34'd17179738112;
            height_reg   <= 36'd34359607296;
            inv_reg      <= 17'd655;
            selfx_reg    <= '0;
            selfy_reg    <= '0;
            selfz_reg    <= '0;
            self_en_reg  <= 1'b0;
            max_out_reg  <= 13'd4096;
            seen_reg     <= '0;
            valid_reg    <= '0;
            rdrop_reg    <= '0;
            hdrop_reg    <= '0;
            sdrop_reg    <= '0;
            vdrop_reg    <= '0;
            kept_reg     <= '0;
            limit_reg    <= 1'b0;
        end else begin
            state_reg    <= state_next;
            addr_reg     <= addr_next;
            emit_reg     <= emit_next;
            m_tvalid_reg <= m_tvalid_next;
            range_reg    <= range_next;
            height_reg   <= height_next;
            inv_reg      <= inv_next;
            selfx_reg    <= selfx_next;
            selfy_reg    <= selfy_next;
            selfz_reg    <= selfz_next;
            self_en_reg  <= self_en_next;
            max_out_reg  <= max_out_next;
            seen_reg     <= seen_next;
            valid_reg    <= valid_next;
            rdrop_reg    <= rdrop_next;
            hdrop_reg    <= hdrop_next;
            sdrop_reg    <= sdrop_next;
            vdrop_reg    <= vdrop_next;
            kept_reg     <= kept_next;
            limit_reg    <= limit_next;
        end
        px_reg       <= px_next;
        py_reg       <= py_next;
        pz_reg       <= pz_next;
        xx_reg       <= xx_next;
        yy_reg       <= yy_next;
        rmin2_reg    <= rmin2_next;
        rmax2_reg    <= rmax2_next;
        key_reg      <= key_next;
        verd_reg     <= verd_next;
        out_reg      <= out_next;
        out_verd_reg <= out_verd_next;
    end

endmodule

// ===== test/voxel_dedup_point_filter_core_test.sv =====
// Self-checking stream testbench for the voxel point filter core.
module voxel_dedup_point_filter_core_test;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [1:0]  user;
        logic [55:0] data;
    } point_word_t;

    typedef struct {
        vdpf_pkg::verdict_t verdict;
        logic [263:0]       data;
    } filter_result_t;

    localparam int NFIELDS = 12;
    localparam int FIELD_LSB [NFIELDS] = '{0, 18, 36, 54, 86, 118, 150, 182, 214, 246, 259, 260};
    localparam int FIELD_LEN [NFIELDS] = '{18, 18, 18, 32, 32, 32, 32, 32, 32, 13, 1, 4};
    localparam string FIELD_NAME [NFIELDS] = '{"out_x_mm", "out_y_mm", "out_z_mm",
        "seen_count", "valid_count", "range_drop_count", "height_drop_count",
        "self_drop_count", "voxel_drop_count", "kept_count", "limit_hit", "pad"};
    localparam int REG_WIDTH [8] = '{34, 36, 17, 36, 36, 36, 1, 13};

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [55:0] s_tdata = '0;
    logic [1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [263:0] m_tdata;
    logic [2:0] m_tuser;
    logic cfg_wr_en = 1'b0;
    logic [vdpf_pkg::IDX_BITS-1:0] cfg_index = '0;
    logic [vdpf_pkg::CFG_BITS-1:0] cfg_wdata = '0;

    voxel_dedup_point_filter_core i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // predictor state
    logic [35:0] filt_reg [8];
    bit occupied [logic [vdpf_pkg::KEY_BITS-1:0]];
    logic [31:0] seen_total, valid_total, range_drops, height_drops, self_drops, voxel_drops;
    logic [12:0] kept_total;
    logic limit_flag;

    point_word_t pending_points [$];
    filter_result_t expected_results [$];
    int mismatches = 0;
    bit hold_input = 1'b0;
    bit long_stall_req = 1'b0;

    function automatic logic [31:0] bump(input logic [31:0] c);
        return (c == 32'hFFFF_FFFF) ? c : c + 32'd1;
    endfunction

    function automatic bit within_bounds(input longint v, input logic [35:0] b);
        logic signed [17:0] lo;
        logic signed [17:0] hi;
        lo = b[17:0];
        hi = b[35:18];
        return v >= longint'(lo) && v <= longint'(hi);
    endfunction

    function automatic logic [17:0] voxel_axis(input longint c, input longint inv);
        longint p;
        p = c * inv;
        return 18'(p >>> vdpf_pkg::FRAC_BITS);
    endfunction

    function automatic vdpf_pkg::verdict_t classify_point(input longint x, input longint y,
                                                          input longint z, input bit ok);
        longint unsigned r2, rmin, rmax, cap;
        logic [vdpf_pkg::KEY_BITS-1:0] key;
        seen_total = bump(seen_total);
        if (!ok)
            return vdpf_pkg::VERD_INVALID;
        valid_total = bump(valid_total);
        rmin = filt_reg[vdpf_pkg::REG_RANGE][16:0];
        rmax = filt_reg[vdpf_pkg::REG_RANGE][33:17];
        r2 = x * x + y * y;
        if (r2 < rmin * rmin || r2 > rmax * rmax) begin
            range_drops = bump(range_drops);
            return vdpf_pkg::VERD_RANGE;
        end
        if (!within_bounds(z, filt_reg[vdpf_pkg::REG_HEIGHT])) begin
            height_drops = bump(height_drops);
            return vdpf_pkg::VERD_HEIGHT;
        end
        if (filt_reg[vdpf_pkg::REG_SELF_EN][0] &&
            within_bounds(x, filt_reg[vdpf_pkg::REG_SELF_X]) &&
            within_bounds(y, filt_reg[vdpf_pkg::REG_SELF_Y]) &&
            within_bounds(z, filt_reg[vdpf_pkg::REG_SELF_Z])) begin
            self_drops = bump(self_drops);
            return vdpf_pkg::VERD_SELF;
        end
        key = {voxel_axis(z, filt_reg[vdpf_pkg::REG_INV]),
               voxel_axis(y, filt_reg[vdpf_pkg::REG_INV]),
               voxel_axis(x, filt_reg[vdpf_pkg::REG_INV])};
        if (occupied.exists(key)) begin
            voxel_drops = bump(voxel_drops);
            return vdpf_pkg::VERD_DUP;
        end
        cap = filt_reg[vdpf_pkg::REG_MAX_OUT];
        if (cap > vdpf_pkg::MAX_POINTS)
            cap = vdpf_pkg::MAX_POINTS;
        if (kept_total >= cap) begin
            limit_flag = 1'b1;
            return vdpf_pkg::VERD_LIMIT;
        end
        occupied[key] = 1'b1;
        kept_total = kept_total + 13'd1;
        return vdpf_pkg::VERD_ACCEPT;
    endfunction

    function automatic void clear_filter();
        occupied.delete();
        seen_total = '0;
        valid_total = '0;
        range_drops = '0;
        height_drops = '0;
        self_drops = '0;
        voxel_drops = '0;
        kept_total = '0;
        limit_flag = 1'b0;
    endfunction

    function automatic filter_result_t filter_point(input point_word_t w);
        filter_result_t r;
        logic signed [17:0] x, y, z;
        x = w.data[17:0];
        y = w.data[35:18];
        z = w.data[53:36];
        if (w.user[0]) begin
            clear_filter();
            r.verdict = vdpf_pkg::VERD_CLEARED;
            x = '0;
            y = '0;
            z = '0;
        end else begin
            r.verdict = classify_point(longint'(x), longint'(y), longint'(z), w.user[1]);
        end
        r.data = {4'b0, limit_flag, kept_total, voxel_drops, self_drops, height_drops,
                  range_drops, valid_total, seen_total, z, y, x};
        return r;
    endfunction

    // drive the point stream in bursts with random gaps
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge aclk) begin
        point_word_t w;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                s_tvalid <= 1'b0;
            end else if (!hold_input && pending_points.size() > 0) begin
                w = pending_points.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= w.data;
                s_tuser <= w.user;
                if (burst_left == 0) begin
                    burst_left <= $urandom_range(1, 12);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result side stalls on its own pattern, plus one long hold-off on request
    int cycle_cnt = 0;
    int long_stall_cnt = 0;
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (long_stall_req && long_stall_cnt < 400) begin
            long_stall_cnt <= long_stall_cnt + 1;
            m_tready <= 1'b0;
        end else if (cycle_cnt[8:7] == 2'b00) begin
            m_tready <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    // predict on each accepted point, check each accepted result word
    always @(posedge aclk) begin
        filter_result_t e;
        point_word_t w_in;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                w_in.user = s_tuser;
                w_in.data = s_tdata;
                expected_results = {expected_results, filter_point(w_in)};
            end
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    if (mismatches < 10)
                        $display("unexpected result word: verdict %0d", m_tuser);
                    mismatches++;
                end else begin
                    e = expected_results.pop_front();
                    if (m_tuser !== e.verdict) begin
                        if (mismatches < 10)
                            $display("verdict: expected %0d got %0d", e.verdict, m_tuser);
                        mismatches++;
                    end
                    for (int f = 0; f < NFIELDS; f++) begin
                        if (((m_tdata ^ e.data) >> FIELD_LSB[f]) & ((264'd1 << FIELD_LEN[f]) - 1)
                            || $isunknown(m_tdata)) begin
                            if (mismatches < 10)
                                $display("%s: expected %0h got %0h", FIELD_NAME[f],
                                         (e.data >> FIELD_LSB[f]) & ((264'd1 << FIELD_LEN[f]) - 1),
                                         (m_tdata >> FIELD_LSB[f]) & ((264'd1 << FIELD_LEN[f]) - 1));
                            mismatches++;
                        end
                    end
                end
            end
        end
    end

    task automatic write_reg(input logic [vdpf_pkg::IDX_BITS-1:0] idx, input logic [35:0] value);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        filt_reg[idx] = value & ((36'd1 << REG_WIDTH[idx]) - 1);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [35:0] span18(input int lo, input int hi);
        return {18'(hi), 18'(lo)};
    endfunction

    function automatic void add_point(input bit clr, input bit ok, input int x, input int y,
                                      input int z);
        point_word_t w;
        w.user = {ok, clr};
        w.data = {2'b0, 18'(z), 18'(y), 18'(x)};
        pending_points = {pending_points, w};
    endfunction

    function automatic int pick_coord(input int span);
        if ($urandom_range(0, 4) == 0)
            return int'($signed(18'($urandom)));
        return $urandom_range(0, 2 * span) - span;
    endfunction

    function automatic void add_random(input int n, input int span, input int zspan);
        for (int i = 0; i < n; i++)
            add_point($urandom_range(0, 49) == 0, $urandom_range(0, 9) != 0,
                      pick_coord(span), pick_coord(span), pick_coord(zspan));
    endfunction

    // let everything drain before touching the registers
    task automatic drain();
        while (pending_points.size() > 0 || s_tvalid || expected_results.size() > 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic load_config(input logic [35:0] rng, input logic [35:0] hgt,
                               input logic [35:0] inv, input logic [35:0] sx,
                               input logic [35:0] sy, input logic [35:0] sz,
                               input logic [35:0] en, input logic [35:0] cap);
        write_reg(vdpf_pkg::REG_RANGE, rng);
        write_reg(vdpf_pkg::REG_HEIGHT, hgt);
        write_reg(vdpf_pkg::REG_INV, inv);
        write_reg(vdpf_pkg::REG_SELF_X, sx);
        write_reg(vdpf_pkg::REG_SELF_Y, sy);
        write_reg(vdpf_pkg::REG_SELF_Z, sz);
        write_reg(vdpf_pkg::REG_SELF_EN, en);
        write_reg(vdpf_pkg::REG_MAX_OUT, cap);
    endtask

    initial begin
        #20ms;
        $display("** voxel_dedup_point_filter_core: FAILED **");
        $finish;
    end

    initial begin
        filt_reg = '{36'd17179738112, 36'd34359607296, 36'd655, 36'd0, 36'd0, 36'd0,
                     36'd0, 36'd4096};
        clear_filter();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // directed points under reset settings
        add_point(1, 0, 5, 5, 5);
        add_point(0, 0, -131072, 131071, -131072);
        add_point(0, 1, 0, 0, 0);
        add_point(0, 1, 50, 50, 50);
        add_point(0, 1, -1, 0, 0);
        add_point(0, 1, 131071, 0, 0);
        add_point(0, 1, 0, -131071, 131071);
        add_point(0, 1, 0, 0, -131072);
        add_point(0, 1, -131072, 0, 0);
        add_point(0, 1, 131071, 131071, 0);
        add_point(0, 1, 0, 0, -131072);
        add_point(1, 1, -1, -1, -1);
        add_point(0, 1, 0, 0, 0);
        drain();

        // tight windows, self box on, small output limit; long result hold-off
        load_config({17'd5000, 17'd100}, span18(-500, 2000), 36'd6554, span18(-300, 300),
                    span18(-300, 300), span18(-100, 100), 36'd1, 36'd25);
        add_point(0, 1, 200, 0, 0);
        add_point(0, 1, 200, 0, 500);
        add_point(0, 1, 90, 0, 0);
        add_point(0, 1, 0, 5001, 0);
        add_point(0, 1, 0, 300, -501);
        long_stall_req = 1'b1;
        add_random(180, 3000, 800);
        drain();

        // extremes: saturated range, inverted height, zero inverse, zero limit
        load_config(36'h3_FFFF_FFFF, span18(131071, -131072), 36'd0, 36'hF_FFFF_FFFF,
                    36'hF_FFFF_FFFF, 36'hF_FFFF_FFFF, 36'd0, 36'd0);
        add_random(40, 131071, 131071);
        drain();

        load_config({17'd131071, 17'd0}, span18(-131072, 131071), 36'd0, 36'd0, 36'd0,
                    36'd0, 36'd1, 36'd0);
        add_point(0, 1, 1, 1, 1);
        add_random(30, 2000, 2000);
        drain();

        // widest inverse and a limit above the cap
        load_config({17'd131071, 17'd0}, span18(-131072, 131071), 36'h1_FFFF,
                    span18(-50, 50), span18(-50, 50), span18(-131072, 131071), 36'd1,
                    36'h1FFF);
        add_random(40, 400, 400);
        drain();

        load_config({17'd100000, 17'd20}, span18(-20000, 20000), 36'd65536,
                    span18(-1000, 1000), span18(-1000, 1000), span18(-2000, 2000), 36'd1,
                    36'd4096);
        add_random(200, 20000, 25000);
        drain();
        repeat (50) @(posedge aclk);

        if (mismatches == 0 && expected_results.size() == 0)
            $display("** voxel_dedup_point_filter_core: PASSED **");
        else
            $display("** voxel_dedup_point_filter_core: FAILED **");
        $finish;
    end
endmodule
